// ----- hw/rtl/gbrg_pkg.sv -----
package gbrg_pkg;

    localparam int CODE_W = 8;
    localparam int NUM_CODES = 256;
    localparam int ROW_W = 4;
    localparam int ROWS_PER_SLOT = 16;

    localparam logic OP_DEFINE = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [ROW_W-1:0] LAST_ROW_8 = 4'd7;
    localparam logic [ROW_W-1:0] LAST_ROW_16 = 4'd15;

    typedef struct packed {
        logic              is_draw;
        logic [ROW_W-1:0]  row;
        logic [15:0]       bits;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [7:0]        color;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_DRAW
    } back_state_t;

endpackage

// ----- hw/rtl/glyph_bank_row_generator_core.sv -----
// A draw passes front stage, queue and draw latch; rows leave one per cycle while m_ready holds.
// The glyph store read port sets the rate: a draw holds the back end while it reads 8 or 16 rows,
// a define is written from idle; the front end takes one word per cycle while its queue has room.
// After reset the glyph store is cleared one row per cycle, all SLOT_CAPACITY * 16 rows
// (2048 by default), while s_ready stays low; configuration writes are taken throughout.
module glyph_bank_row_generator_core #(
    parameter int SLOT_CAPACITY = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_glyph_mode,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [7:0]         s_char_code,
    input  logic [3:0]         s_row_index,
    input  logic [15:0]        s_row_bits,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [7:0]         s_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_x,
    output logic signed [15:0] m_out_y,
    output logic [15:0]        m_out_bits,
    output logic [7:0]         m_out_color,
    output logic               m_last_row
);

    import gbrg_pkg::*;

    localparam int SLOT_W = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int Q_W = $bits(cmd_t) + SLOT_W;

    logic              glyph_mode_reg;
    logic              clear_done;
    logic              push_valid;
    logic              push_ready;
    cmd_t              push_cmd;
    logic [SLOT_W-1:0] push_slot;
    logic              pop_valid;
    logic              pop_ready;
    logic [Q_W-1:0]    pop_data;
    cmd_t              pop_cmd;
    logic [SLOT_W-1:0] pop_slot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            glyph_mode_reg <= cfg_glyph_mode;
        end
    end

    gbrg_front #(
        .SLOT_CAPACITY (SLOT_CAPACITY),
        .SLOT_W        (SLOT_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .glyph_mode  (glyph_mode_reg),
        .clear_done  (clear_done),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_char_code (s_char_code),
        .s_row_index (s_row_index),
        .s_row_bits  (s_row_bits),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_color     (s_color),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd),
        .push_slot   (push_slot)
    );

    gbrg_cmd_fifo #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_cmd, push_slot}),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    assign pop_cmd = pop_data[Q_W-1:SLOT_W];
    assign pop_slot = pop_data[SLOT_W-1:0];

    gbrg_back #(
        .SLOT_CAPACITY (SLOT_CAPACITY),
        .SLOT_W        (SLOT_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .glyph_mode  (glyph_mode_reg),
        .clear_done  (clear_done),
        .cmd_valid   (pop_valid),
        .cmd_ready   (pop_ready),
        .cmd         (pop_cmd),
        .cmd_slot    (pop_slot),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_bits  (m_out_bits),
        .m_out_color (m_out_color),
        .m_last_row  (m_last_row)
    );

endmodule

// ----- hw/rtl/gbrg_ram.sv -----
module gbrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/gbrg_front.sv -----
module gbrg_front #(
    parameter int SLOT_CAPACITY = 128,
    parameter int SLOT_W = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               glyph_mode,
    input  logic               clear_done,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [7:0]         s_char_code,
    input  logic [3:0]         s_row_index,
    input  logic [15:0]        s_row_bits,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [7:0]         s_color,
    output logic               push_valid,
    input  logic               push_ready,
    output gbrg_pkg::cmd_t     push_cmd,
    output logic [SLOT_W-1:0]  push_slot
);

    import gbrg_pkg::*;

    localparam int CNT_W = $clog2(SLOT_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(SLOT_CAPACITY);

    logic [NUM_CODES-1:0] valid_reg;
    logic [CNT_W-1:0]     used_reg;
    logic                 st1_valid_reg;
    cmd_t                 st1_cmd_reg;
    logic                 st1_alloc_reg;
    logic [SLOT_W-1:0]    st1_new_slot_reg;
    logic [SLOT_W-1:0]    map_rdata;

    logic accept;
    logic is_draw;
    logic mapped;
    logic full;
    logic row_ok;
    logic alloc;
    logic keep;

    assign accept = s_valid && s_ready;
    assign is_draw = (s_operation == OP_DRAW);
    assign mapped = valid_reg[s_char_code];
    assign full = (used_reg >= CAPACITY);
    assign row_ok = glyph_mode || !s_row_index[3];
    assign alloc = !is_draw && row_ok && !mapped && !full;
    assign keep = is_draw ? mapped : (row_ok && (mapped || !full));

    assign s_ready = clear_done && (!st1_valid_reg || push_ready);
    assign push_valid = st1_valid_reg;
    assign push_cmd = st1_cmd_reg;
    assign push_slot = st1_alloc_reg ? st1_new_slot_reg : map_rdata;

    gbrg_ram #(
        .WIDTH  (SLOT_W),
        .DEPTH  (NUM_CODES),
        .ADDR_W (CODE_W)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (accept && alloc),
        .waddr (s_char_code),
        .wdata (used_reg[SLOT_W-1:0]),
        .re    (accept),
        .raddr (s_char_code),
        .rdata (map_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st1_valid_reg <= keep;
                if (alloc) begin
                    valid_reg[s_char_code] <= 1'b1;
                    used_reg <= used_reg + 1'b1;
                end
            end else if (push_ready) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_cmd_reg.is_draw <= is_draw;
            st1_cmd_reg.row <= s_row_index;
            st1_cmd_reg.bits <= glyph_mode ? s_row_bits : {8'h00, s_row_bits[7:0]};
            st1_cmd_reg.px <= s_pos_x;
            st1_cmd_reg.py <= s_pos_y;
            st1_cmd_reg.color <= s_color;
            st1_alloc_reg <= alloc;
            st1_new_slot_reg <= used_reg[SLOT_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/gbrg_cmd_fifo.sv -----
module gbrg_cmd_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0] data_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    logic push;
    logic pop;

    assign in_ready = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data = data_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- hw/rtl/gbrg_back.sv -----
module gbrg_back #(
    parameter int SLOT_CAPACITY = 128,
    parameter int SLOT_W = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               glyph_mode,
    output logic               clear_done,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  gbrg_pkg::cmd_t     cmd,
    input  logic [SLOT_W-1:0]  cmd_slot,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_x,
    output logic signed [15:0] m_out_y,
    output logic [15:0]        m_out_bits,
    output logic [7:0]         m_out_color,
    output logic               m_last_row
);

    import gbrg_pkg::*;

    localparam int DEPTH = SLOT_CAPACITY * ROWS_PER_SLOT;
    localparam int ADDR_W = SLOT_W + ROW_W;
    localparam logic [ADDR_W-1:0] LAST_CLEAR = ADDR_W'(DEPTH - 1);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [ADDR_W-1:0]  clr_cnt_next;
    logic [ROW_W-1:0]   row_cnt_reg;
    logic [ROW_W-1:0]   row_cnt_next;

    logic [SLOT_W-1:0]  draw_slot_reg;
    logic signed [15:0] draw_px_reg;
    logic signed [15:0] draw_py_reg;
    logic [7:0]         draw_color_reg;

    logic               rd_valid_reg;
    logic signed [15:0] rd_x_reg;
    logic signed [15:0] rd_y_reg;
    logic [7:0]         rd_color_reg;
    logic               rd_last_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_x_reg;
    logic signed [15:0] m_y_reg;
    logic [15:0]        m_bits_reg;
    logic [7:0]         m_color_reg;
    logic               m_last_reg;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [15:0]        wdata;
    logic               issue;
    logic               latch_draw;
    logic [15:0]        rdata;
    logic               out_load;
    logic               issue_ok;
    logic [ROW_W-1:0]   last_idx;

    assign out_load = rd_valid_reg && (!m_valid_reg || m_ready);
    assign issue_ok = !rd_valid_reg || out_load;
    assign last_idx = glyph_mode ? LAST_ROW_16 : LAST_ROW_8;
    assign clear_done = (state_reg != BK_CLEAR);

    gbrg_ram #(
        .WIDTH  (16),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (issue),
        .raddr ({draw_slot_reg, row_cnt_reg}),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_CLEAR;
            clr_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        row_cnt_next = row_cnt_reg;
        cmd_ready = 1'b0;
        we = 1'b0;
        waddr = clr_cnt_reg;
        wdata = '0;
        issue = 1'b0;
        latch_draw = 1'b0;
        case (state_reg)
            BK_CLEAR: begin
                we = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_CLEAR) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    if (cmd.is_draw) begin
                        latch_draw = 1'b1;
                        row_cnt_next = '0;
                        state_next = BK_DRAW;
                    end else begin
                        we = 1'b1;
                        waddr = {cmd_slot, cmd.row};
                        wdata = cmd.bits;
                    end
                end
            end
            BK_DRAW: begin
                if (issue_ok) begin
                    issue = 1'b1;
                    row_cnt_next = row_cnt_reg + 1'b1;
                    if (row_cnt_reg == last_idx) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                rd_valid_reg <= 1'b1;
            end else if (out_load) begin
                rd_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (latch_draw) begin
            draw_slot_reg <= cmd_slot;
            draw_px_reg <= cmd.px;
            draw_py_reg <= cmd.py;
            draw_color_reg <= cmd.color;
        end
        if (issue) begin
            rd_x_reg <= draw_px_reg;
            rd_y_reg <= draw_py_reg + signed'({12'd0, row_cnt_reg});
            rd_color_reg <= draw_color_reg;
            rd_last_reg <= (row_cnt_reg == last_idx);
        end
        if (out_load) begin
            m_x_reg <= rd_x_reg;
            m_y_reg <= rd_y_reg;
            m_bits_reg <= glyph_mode ? rdata : {8'h00, rdata[7:0]};
            m_color_reg <= rd_color_reg;
            m_last_reg <= rd_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = m_x_reg;
    assign m_out_y = m_y_reg;
    assign m_out_bits = m_bits_reg;
    assign m_out_color = m_color_reg;
    assign m_last_row = m_last_reg;

endmodule
